### rtl/rdma_target_memory_engine_defines.svh
// Assertion macros used by the checker file of the target memory engine.
// Each macro takes a label, the clock, the active-low reset, a trigger and a
// consequence, and reports through $error alone.
`ifndef RDMA_TARGET_MEMORY_ENGINE_DEFINES_SVH
`define RDMA_TARGET_MEMORY_ENGINE_DEFINES_SVH

// The consequence must hold at the same edge as the trigger.
`define RTME_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtme: same-cycle check failed");

// The consequence must hold at the edge after the trigger.
`define RTME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtme: next-cycle check failed");

`endif

### rtl/rtme_pkg.sv
`default_nettype none

package rtme_pkg;

    // Field widths of the command and result items.
    localparam int OP_W         = 3;
    localparam int NODE_W       = 2;
    localparam int TGT_BYTE_W   = 48;
    localparam int TGT_WORD_W   = 46;
    localparam int STORE_BYTE_W = 12;
    localparam int SW_W         = 10;
    localparam int SW_MAX       = 1023;
    localparam int LEN_W        = 9;
    localparam int CNT_W        = 7;
    localparam int DATA_W       = 64;
    localparam int WORD_W       = 32;

    // Defaults of the top level parameters.
    localparam int NODE_COUNT_DEF     = 4;
    localparam int WORDS_PER_NODE_DEF = 1024;
    localparam int MAX_BURST_DEF      = 64;

    // Most words a write command stores.
    localparam int WRITE_MAX_WORDS = 2;

    // Command codes.
    localparam logic [OP_W-1:0] OP_READ  = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_WRITE
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic clr_step;
        logic capture;
        logic red_step;
        logic ptr_load;
        logic rd_load;
        logic wr_step;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clr_done;
        logic in_is_read;
        logic in_is_write;
        logic red_done;
        logic is_read;
        logic last_one;
        logic out_free;
    } t_dp_status;

    // Number of conditional subtract steps that bring a store word index
    // below the node size.
    function automatic int red_steps(input int wpn);
        int n;
        n = 0;
        for (int k = 0; k < SW_W; k++) begin
            if ((wpn << k) <= SW_MAX) begin
                n++;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### rtl/rtme_ctrl.sv
`default_nettype none

module rtme_ctrl
    import rtme_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_status.in_is_read || i_status.in_is_write) begin
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (i_status.red_done) begin
                    o_cmd.ptr_load = 1'b1;
                    n_state = i_status.is_read ? ST_READ : ST_WRITE;
                end else begin
                    o_cmd.red_step = 1'b1;
                end
            end
            ST_READ: begin
                if (i_status.out_free) begin
                    o_cmd.rd_load = 1'b1;
                    if (i_status.last_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_WRITE: begin
                o_cmd.wr_step = 1'b1;
                if (i_status.last_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/rtme_datapath.sv
`default_nettype none

module rtme_datapath
    import rtme_pkg::*;
#(
    parameter int NODE_COUNT     = NODE_COUNT_DEF,
    parameter int WORDS_PER_NODE = WORDS_PER_NODE_DEF,
    parameter int MAX_BURST      = MAX_BURST_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    input  wire [OP_W-1:0]           i_operation,
    input  wire [NODE_W-1:0]         i_node,
    input  wire [TGT_BYTE_W-1:0]     i_target_byte_address,
    input  wire [STORE_BYTE_W-1:0]   i_store_byte_address,
    input  wire [LEN_W-1:0]          i_byte_length,
    input  wire [DATA_W-1:0]         i_write_data,
    input  wire                      i_stall,
    output logic                     o_valid,
    output logic [TGT_WORD_W-1:0]    o_target_word_address,
    output logic [WORD_W-1:0]        o_read_word,
    output logic                     o_last_word
);

    localparam int MEM_DEPTH = NODE_COUNT * WORDS_PER_NODE;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int LW        = $clog2(WORDS_PER_NODE);
    localparam int RED_STEPS = red_steps(WORDS_PER_NODE);
    localparam int RKW       = $clog2(RED_STEPS + 2);

    logic [WORD_W-1:0] mem [MEM_DEPTH];

    logic [AW-1:0]         r_clr_addr;
    logic [AW-1:0]         r_base;
    logic [SW_W-1:0]       r_sw;
    logic [RKW-1:0]        r_red_left;
    logic [LW-1:0]         r_ptr;
    logic [CNT_W-1:0]      r_left;
    logic                  r_is_read;
    logic [TGT_WORD_W-1:0] r_tgt;
    logic [DATA_W-1:0]     r_wdata;
    logic                  r_out_valid;
    logic [TGT_WORD_W-1:0] r_out_tgt;
    logic [WORD_W-1:0]     r_rdata;
    logic                  r_out_last;

    logic [CNT_W-1:0]  in_words;
    logic              in_node_ok;
    logic [CNT_W-1:0]  n_left;
    logic [31:0]       red_sub;
    logic [LW-1:0]     n_ptr;
    logic [AW-1:0]     mem_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    always_comb begin
        in_words   = i_byte_length[LEN_W-1:2];
        in_node_ok = (32'(i_node) < NODE_COUNT);
        if (i_operation == OP_READ) begin
            n_left = (32'(in_words) > MAX_BURST) ? CNT_W'(MAX_BURST) : in_words;
        end else begin
            n_left = (32'(in_words) > WRITE_MAX_WORDS) ? CNT_W'(WRITE_MAX_WORDS) : in_words;
        end
        red_sub   = 32'(WORDS_PER_NODE) << (r_red_left - RKW'(1));
        n_ptr     = (r_ptr == LW'(WORDS_PER_NODE - 1)) ? '0 : r_ptr + LW'(1);
        mem_addr  = r_base + AW'(r_ptr);
        mem_we    = i_cmd.clr_step || i_cmd.wr_step;
        mem_waddr = i_cmd.clr_step ? r_clr_addr : mem_addr;
        mem_wdata = i_cmd.clr_step ? '0 : r_wdata[WORD_W-1:0];
    end

    always_comb begin
        o_status.clr_done    = (r_clr_addr == AW'(MEM_DEPTH - 1));
        o_status.in_is_read  = (i_operation == OP_READ) && in_node_ok && (in_words != '0);
        o_status.in_is_write = (i_operation == OP_WRITE) && in_node_ok && (in_words != '0);
        o_status.red_done    = (r_red_left == '0);
        o_status.is_read     = r_is_read;
        o_status.last_one    = (r_left == CNT_W'(1));
        o_status.out_free    = !r_out_valid || !i_stall;
    end

    // Store: one write port shared by the clearing sweep and writes, one
    // registered read port that feeds the output register directly.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd_load) begin
            r_rdata <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.rd_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_base     <= AW'(32'(i_node) * WORDS_PER_NODE);
            r_sw       <= i_store_byte_address[STORE_BYTE_W-1:2];
            r_red_left <= RKW'(RED_STEPS);
            r_left     <= n_left;
            r_is_read  <= (i_operation == OP_READ);
            r_tgt      <= i_target_byte_address[TGT_BYTE_W-1:2];
            r_wdata    <= i_write_data;
        end
        if (i_cmd.red_step) begin
            if (32'(r_sw) >= red_sub) begin
                r_sw <= SW_W'(32'(r_sw) - red_sub);
            end
            r_red_left <= r_red_left - RKW'(1);
        end
        if (i_cmd.ptr_load) begin
            r_ptr <= LW'(r_sw);
        end
        if (i_cmd.rd_load) begin
            r_out_tgt  <= r_tgt;
            r_out_last <= (r_left == CNT_W'(1));
            r_tgt      <= r_tgt + TGT_WORD_W'(1);
            r_ptr      <= n_ptr;
            r_left     <= r_left - CNT_W'(1);
        end
        if (i_cmd.wr_step) begin
            r_wdata <= r_wdata >> WORD_W;
            r_ptr   <= n_ptr;
            r_left  <= r_left - CNT_W'(1);
        end
    end

    assign o_valid               = r_out_valid;
    assign o_target_word_address = r_out_tgt;
    assign o_read_word           = r_rdata;
    assign o_last_word           = r_out_last;

endmodule

`default_nettype wire

### rtl/rdma_target_memory_engine.sv
// Channel   Direction  Handshake           Payload
// command   in         i_valid / o_stall   operation, node, addresses, length, write data
// result    out        o_valid / i_stall   target word address, read word, last marker
//
// After reset the store is swept to zero, one word a cycle, over all
// NODE_COUNT * WORDS_PER_NODE words (4096 by default) while o_stall is high.
// A read moves N words and a write N of at most two words after R index reduction
// steps, zero when WORDS_PER_NODE exceeds 1023; an ignored command is dropped when
// taken. A burst moves one word a cycle while its result is not stalled; a stalled
// result holds in the output register and pauses the burst.
`default_nettype none

module rdma_target_memory_engine
    import rtme_pkg::*;
#(
    parameter int NODE_COUNT     = NODE_COUNT_DEF,
    parameter int WORDS_PER_NODE = WORDS_PER_NODE_DEF,
    parameter int MAX_BURST      = MAX_BURST_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_stall,
    input  wire [OP_W-1:0]           i_operation,
    input  wire [NODE_W-1:0]         i_node,
    input  wire [TGT_BYTE_W-1:0]     i_target_byte_address,
    input  wire [STORE_BYTE_W-1:0]   i_store_byte_address,
    input  wire [LEN_W-1:0]          i_byte_length,
    input  wire [DATA_W-1:0]         i_write_data,
    output logic                     o_valid,
    input  wire                      i_stall,
    output logic [TGT_WORD_W-1:0]    o_target_word_address,
    output logic [WORD_W-1:0]        o_read_word,
    output logic                     o_last_word
);

    // The controller sequences the clearing sweep, the capture of a command,
    // the reduction of the store index and the word loop of a burst. The
    // datapath holds the store, the address and count registers and the
    // output register, and reports what the controller needs to decide.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    rtme_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_stall  (o_stall)
    );

    // The output register is loaded straight from the store's read port, so
    // a new command can be accepted while the last word of a burst still
    // waits to be taken.
    rtme_datapath #(
        .NODE_COUNT     (NODE_COUNT),
        .WORDS_PER_NODE (WORDS_PER_NODE),
        .MAX_BURST      (MAX_BURST)
    ) u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (dp_cmd),
        .o_status              (dp_status),
        .i_operation           (i_operation),
        .i_node                (i_node),
        .i_target_byte_address (i_target_byte_address),
        .i_store_byte_address  (i_store_byte_address),
        .i_byte_length         (i_byte_length),
        .i_write_data          (i_write_data),
        .i_stall               (i_stall),
        .o_valid               (o_valid),
        .o_target_word_address (o_target_word_address),
        .o_read_word           (o_read_word),
        .o_last_word           (o_last_word)
    );

endmodule

`default_nettype wire

### rtl/rtme_checker.sv
`default_nettype none

`include "rdma_target_memory_engine_defines.svh"

module rtme_checker
    import rtme_pkg::*;
(
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    o_stall,
    input wire                    o_valid,
    input wire                    i_stall,
    input wire [TGT_WORD_W-1:0]   o_target_word_address,
    input wire [WORD_W-1:0]       o_read_word,
    input wire                    o_last_word
);

    // A stalled result keeps its payload.
    `RTME_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_read_word) && $stable(o_target_word_address) && $stable(o_last_word))

    // The clearing sweep starts right after reset: no command taken, no result shown.
    `RTME_ASSERT_SAME(a_clear, i_clk, i_rst_n, $rose(i_rst_n), o_stall && !o_valid)

    // Inside a burst the next word follows at once, one word address further on.
    `RTME_ASSERT_NEXT(a_burst, i_clk, i_rst_n, o_valid && !i_stall && !o_last_word, o_valid && (o_target_word_address == $past(o_target_word_address) + 46'd1))

    // No new command enters while a burst is still under way.
    `RTME_ASSERT_SAME(a_busy, i_clk, i_rst_n, o_valid && !o_last_word, o_stall)

endmodule

bind rdma_target_memory_engine rtme_checker u_rtme_checker (.*);

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import rtme_pkg::*;

    // Opcodes that the engine must ignore. Only read and write have meaning.
    localparam logic [OP_W-1:0] OP_SPARE_2 = 3'd2;
    localparam logic [OP_W-1:0] OP_SPARE_3 = 3'd3;
    localparam logic [OP_W-1:0] OP_SPARE_4 = 3'd4;
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 360;
    localparam int IDLE_PERCENT  = 29;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 100;
    // The store sweep after reset alone writes 4096 words. A run where every
    // item is a full 64 word burst against a stalling receiver stays well
    // below this limit.
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int REPORT_LIMIT  = 10;

    // Random traffic aims most store addresses at a small window so that
    // reads often return words that earlier writes left behind.
    localparam logic [STORE_BYTE_W-1:0] HOT_BASE = 12'h100;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [NODE_W-1:0]       node;
        logic [TGT_BYTE_W-1:0]   tgt;
        logic [STORE_BYTE_W-1:0] saddr;
        logic [LEN_W-1:0]        len;
        logic [DATA_W-1:0]       data;
    } t_command;

    typedef struct packed {
        logic [TGT_WORD_W-1:0] addr;
        logic [WORD_W-1:0]     word;
        logic                  last;
    } t_beat;

    // How a directed row is checked: against the predictor, or against a
    // result typed into the table (no result at all, or exactly one beat).
    typedef enum logic [1:0] {
        FROM_MODEL,
        TYPED_NONE,
        TYPED_ONE
    } t_row_check;

    typedef struct packed {
        t_command   cmd;
        t_row_check check;
        t_beat      beat;
    } t_row;

    localparam int DIRECTED_ROWS = 24;

    // The directed part. The first rows read a store that is still all
    // zero, so their single beat can be typed in directly. Writes and
    // ignored opcodes never produce a result.
    t_row directed_rows [DIRECTED_ROWS] = '{
        // One word at the bottom of node 0, fresh after reset.
        '{'{OP_READ,  2'd0, 48'h0,            12'h000, 9'd4,   64'h0},
          TYPED_ONE, '{46'h0, 32'h0, 1'b1}},
        // Highest node, highest store word, highest requester address.
        '{'{OP_READ,  2'd3, 48'hFFFF_FFFF_FFFF, 12'hFFC, 9'd4, 64'h0},
          TYPED_ONE, '{46'h3FFF_FFFF_FFFF, 32'h0, 1'b1}},
        // A length under one word reads nothing.
        '{'{OP_READ,  2'd1, 48'h1234,         12'h010, 9'd3,   64'h0},
          TYPED_NONE, '0},
        '{'{OP_READ,  2'd2, 48'h0,            12'h000, 9'd0,   64'h0},
          TYPED_NONE, '0},
        // Two words into node 0, then read back.
        '{'{OP_WRITE, 2'd0, 48'h0,            12'h000, 9'd8,
            64'hDEAD_BEEF_0123_4567}, TYPED_NONE, '0},
        '{'{OP_READ,  2'd0, 48'h100,          12'h000, 9'd8,   64'h0},
          FROM_MODEL, '0},
        // A write across the top of node 1 wraps to its word zero.
        '{'{OP_WRITE, 2'd1, 48'h0,            12'hFFC, 9'd8,
            64'hCAFE_F00D_A5A5_A5A5}, TYPED_NONE, '0},
        '{'{OP_READ,  2'd1, 48'h0,            12'hFF8, 9'd16,  64'h0},
          FROM_MODEL, '0},
        // A long write stores only two words.
        '{'{OP_WRITE, 2'd2, 48'h0,            12'h010, 9'd256,
            64'hFFFF_FFFF_FFFF_FFFF}, TYPED_NONE, '0},
        '{'{OP_READ,  2'd2, 48'h40,           12'h008, 9'd24,  64'h0},
          FROM_MODEL, '0},
        // One word, then a short write that must leave the store alone.
        '{'{OP_WRITE, 2'd3, 48'h0,            12'h020, 9'd4,
            64'h89AB_CDEF_7654_3210}, TYPED_NONE, '0},
        '{'{OP_WRITE, 2'd3, 48'h0,            12'h024, 9'd2,
            64'h1111_1111_2222_2222}, TYPED_NONE, '0},
        // The longest length caps at a full burst and the requester word
        // address wraps past its top.
        '{'{OP_READ,  2'd3, 48'hFFFF_FFFF_FFF0, 12'h020, 9'd511, 64'h0},
          FROM_MODEL, '0},
        // Every spare opcode, shaped like a write that would clobber node 0.
        '{'{OP_SPARE_2, 2'd0, 48'h0, 12'h000, 9'd8, 64'h0}, TYPED_NONE, '0},
        '{'{OP_SPARE_3, 2'd0, 48'h0, 12'h000, 9'd8, 64'h0}, TYPED_NONE, '0},
        '{'{OP_SPARE_4, 2'd0, 48'h0, 12'h000, 9'd8, 64'h0}, TYPED_NONE, '0},
        '{'{OP_SPARE_5, 2'd0, 48'h0, 12'h000, 9'd8, 64'h0}, TYPED_NONE, '0},
        '{'{OP_SPARE_6, 2'd0, 48'h0, 12'h000, 9'd8, 64'h0}, TYPED_NONE, '0},
        '{'{OP_SPARE_7, 2'd0, 48'h0, 12'h000, 9'd8, 64'h0}, TYPED_NONE, '0},
        '{'{OP_READ,  2'd0, 48'h0,            12'h000, 9'd8,   64'h0},
          FROM_MODEL, '0},
        // A full burst that wraps around the end of node 0.
        '{'{OP_READ,  2'd0, 48'h8000_0000_0003, 12'hFC0, 9'd256, 64'h0},
          FROM_MODEL, '0},
        // Low address and length bits are dropped.
        '{'{OP_READ,  2'd2, 48'h7,            12'h003, 9'd7,   64'h0},
          FROM_MODEL, '0},
        '{'{OP_WRITE, 2'd0, 48'h0,            12'h7FF, 9'd9,   64'h0},
          TYPED_NONE, '0},
        '{'{OP_READ,  2'd0, 48'h0,            12'h7FC, 9'd12,  64'h0},
          FROM_MODEL, '0}
    };

    // Ports of the engine; the inputs are at known values from time zero.
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [OP_W-1:0]         i_operation = '0;
    logic [NODE_W-1:0]       i_node = '0;
    logic [TGT_BYTE_W-1:0]   i_target_byte_address = '0;
    logic [STORE_BYTE_W-1:0] i_store_byte_address = '0;
    logic [LEN_W-1:0]        i_byte_length = '0;
    logic [DATA_W-1:0]       i_write_data = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [TGT_WORD_W-1:0]   o_target_word_address;
    logic [WORD_W-1:0]       o_read_word;
    logic                    o_last_word;

    // The testbench's own image of every node store, and the read beats
    // that the engine still owes, oldest first.
    logic [WORD_W-1:0] store_image [NODE_COUNT_DEF][WORDS_PER_NODE_DEF];
    t_beat             read_beats_due [$];

    int mismatches = 0;

    // Idle controls. The sender's flag is only used by its own process; the
    // receiver's flag and the long hold request are passed across by
    // nonblocking assignment.
    bit feed_idles = 1'b1;
    bit sink_idles = 1'b1;
    bit hold_req = 1'b0;
    bit hold_ack = 1'b0;
    int hold_left = 0;

    rdma_target_memory_engine dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_operation           (i_operation),
        .i_node                (i_node),
        .i_target_byte_address (i_target_byte_address),
        .i_store_byte_address  (i_store_byte_address),
        .i_byte_length         (i_byte_length),
        .i_write_data          (i_write_data),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_target_word_address (o_target_word_address),
        .o_read_word           (o_read_word),
        .o_last_word           (o_last_word)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predicts one accepted command. A write updates the store image and
    // yields nothing; a read yields one beat per word, capped at a full
    // burst. Store word indexes wrap within the node, requester word
    // addresses wrap at 46 bits. Unknown opcodes fall through untouched.
    function automatic void model_command(input t_command c, ref t_beat beats[$]);
        int    words;
        int    slot;
        t_beat b;
        words = int'(c.len) >> 2;
        if (c.node >= NODE_COUNT_DEF) begin
            return;
        end
        if (c.op == OP_READ) begin
            if (words > MAX_BURST_DEF) begin
                words = MAX_BURST_DEF;
            end
            for (int i = 0; i < words; i++) begin
                slot   = (int'(c.saddr[STORE_BYTE_W-1:2]) + i) % WORDS_PER_NODE_DEF;
                b.addr = c.tgt[TGT_BYTE_W-1:2] + TGT_WORD_W'(i);
                b.word = store_image[c.node][slot];
                b.last = (i == words - 1);
                beats.push_back(b);
            end
        end else if (c.op == OP_WRITE) begin
            if (words > WRITE_MAX_WORDS) begin
                words = WRITE_MAX_WORDS;
            end
            for (int i = 0; i < words; i++) begin
                slot = (int'(c.saddr[STORE_BYTE_W-1:2]) + i) % WORDS_PER_NODE_DEF;
                store_image[c.node][slot] = c.data[WORD_W*i +: WORD_W];
            end
        end
    endfunction

    // Random traffic: mostly reads and writes with random content, plus
    // a share of ignored opcodes. Most lengths are short, a few reach the
    // full burst and beyond it.
    function automatic t_command random_command();
        t_command    c;
        int unsigned pick;
        pick    = $urandom_range(99);
        c.node  = NODE_W'($urandom_range(NODE_COUNT_DEF - 1));
        c.tgt   = TGT_BYTE_W'({$urandom, $urandom});
        if ($urandom_range(9) == 0) begin
            c.tgt[TGT_BYTE_W-1:8] = '1;
        end
        if ($urandom_range(99) < 70) begin
            c.saddr = HOT_BASE + STORE_BYTE_W'($urandom_range(63));
        end else begin
            c.saddr = STORE_BYTE_W'($urandom);
        end
        c.data = {$urandom, $urandom};
        if (pick < 45) begin
            c.op = OP_READ;
            pick = $urandom_range(99);
            if (pick < 60) begin
                c.len = LEN_W'($urandom_range(40));
            end else if (pick < 90) begin
                c.len = LEN_W'($urandom_range(256));
            end else begin
                c.len = LEN_W'($urandom_range(511, 257));
            end
        end else if (pick < 88) begin
            c.op  = OP_WRITE;
            c.len = ($urandom_range(99) < 70) ? LEN_W'($urandom_range(11, 4))
                                              : LEN_W'($urandom_range(511));
        end else begin
            c.op  = OP_W'($urandom_range(OP_SPARE_7, OP_SPARE_2));
            c.len = LEN_W'($urandom_range(511));
        end
        return c;
    endfunction

    function automatic void report_mismatch(input string what, input t_beat want,
                                            input t_beat got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%s: expected addr=%h word=%h last=%b, got addr=%h word=%h last=%b",
                     what, want.addr, want.word, want.last, got.addr, got.word, got.last);
        end
    endfunction

    // Offers one command, possibly after a few idle cycles, and holds it
    // until the engine takes it. At the accepting edge the prediction is
    // queued: from the predictor, or the beat typed into the table. The
    // predictor runs either way so that the store image stays current.
    task automatic send_command(input t_command c, input t_row_check check,
                                input t_beat typed);
        t_beat beats [$];
        while (feed_idles && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid               <= 1'b1;
        i_operation           <= c.op;
        i_node                <= c.node;
        i_target_byte_address <= c.tgt;
        i_store_byte_address  <= c.saddr;
        i_byte_length         <= c.len;
        i_write_data          <= c.data;
        do begin
            @(posedge i_clk);
        end while (o_stall !== 1'b0);
        model_command(c, beats);
        if (check == FROM_MODEL) begin
            foreach (beats[k]) begin
                read_beats_due.push_back(beats[k]);
            end
        end else if (check == TYPED_ONE) begin
            read_beats_due.push_back(typed);
        end
    endtask

    // Stops offering commands until every owed beat has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (read_beats_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Receiver. A long hold is requested by toggling hold_req; this process
    // counts it out on its own. Otherwise it stalls at random while idling
    // is enabled.
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= sink_idles && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Result checker. A beat is taken at an edge where o_valid is high and
    // i_stall is low; both are sampled as they stood before the edge.
    always @(posedge i_clk) begin : result_check
        t_beat got;
        t_beat want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            got.addr = o_target_word_address;
            got.word = o_read_word;
            got.last = o_last_word;
            if (read_beats_due.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = read_beats_due.pop_front();
                if (got.addr !== want.addr || got.word !== want.word ||
                    got.last !== want.last) begin
                    report_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // Watchdog. Ends a run that hangs, for example on a command that is
    // never accepted or a beat that never arrives.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : command_source
        t_beat left;
        for (int n = 0; n < NODE_COUNT_DEF; n++) begin
            for (int w = 0; w < WORDS_PER_NODE_DEF; w++) begin
                store_image[n][w] = '0;
            end
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The engine sweeps its store after reset with o_stall high, so the
        // first command simply waits until it is taken.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_command(directed_rows[r].cmd, directed_rows[r].check,
                         directed_rows[r].beat);
        end

        // Random part. Early on the receiver holds off for a long stretch
        // while commands keep coming, which fills the engine and stalls its
        // input. Later the sender waits for every owed beat, and a stretch
        // follows with no idling on either side.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 90) begin
                hold_req <= ~hold_req;
            end
            if (n == 180) begin
                drain_results();
                feed_idles = 1'b0;
                sink_idles <= 1'b0;
            end
            if (n == 260) begin
                feed_idles = 1'b1;
                sink_idles <= 1'b1;
            end
            send_command(random_command(), FROM_MODEL, '0);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (read_beats_due.size() != 0) begin
            left = read_beats_due.pop_front();
            report_mismatch("missing result", left, '0);
        end

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
